@@ rtl/nlej_pkg.sv @@
package nlej_pkg;

  localparam int unsigned PortW = 32;

  localparam logic [1:0] KEY_ID   = 2'd0;
  localparam logic [1:0] KEY_VAL1 = 2'd1;
  localparam logic [1:0] KEY_VAL2 = 2'd2;
  localparam logic [1:0] KEY_NONE = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PortW-1:0] row_id;
    logic [PortW-1:0] row_val1;
    logic [PortW-1:0] row_val2;
  } in_t;

  typedef struct packed {
    logic [PortW-1:0] match_id;
    logic [PortW-1:0] match_val1;
    logic [PortW-1:0] match_val2;
    logic             last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic probe;
    logic rd;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic last_addr;
  } sts_t;

endpackage

@@ rtl/nlej_ctrl.sv @@
module nlej_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  nlej_pkg::sts_t sts_i,
  output nlej_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import nlej_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.probe = 1'b1;
            if (!sts_i.empty) state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last_addr) state_d = ST_DRAIN;
      end
      // compare of the final row read happens here
      ST_DRAIN: state_d = ST_FLUSH;
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

@@ rtl/nlej_datapath.sv @@
module nlej_datapath #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_data_i,
  input  nlej_pkg::in_t  item_i,
  input  nlej_pkg::cmd_t cmd_i,
  output nlej_pkg::sts_t sts_o,
  output logic           result_valid_o,
  output nlej_pkg::out_t result_o
);
  import nlej_pkg::*;

  localparam int unsigned SW = FIELD_WIDTH;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  function automatic logic [SW-1:0] to_sw(input logic [PortW-1:0] v);
    logic [63:0] e;
    e = {32'b0, v};
    return e[SW-1:0];
  endfunction

  function automatic logic [PortW-1:0] from_sw(input logic [SW-1:0] v);
    logic [63:0] e;
    e = '0;
    e[SW-1:0] = v;
    return e[PortW-1:0];
  endfunction

  logic [3*SW-1:0] mem [TABLE_DEPTH];
  logic [3*SW-1:0] rd_data_q;
  logic            rd_valid_q;
  logic [1:0]      key_sel_q;
  logic [SW-1:0]   probe_key_q;
  logic [CW-1:0]   row_count_q;
  logic [AW-1:0]   scan_q;
  logic [3*SW-1:0] pend_q;
  logic            pend_valid_q;
  logic            out_valid_q, out_valid_d;
  out_t            out_q;

  logic          full;
  logic [SW-1:0] rd_id, rd_v1, rd_v2, rd_key;
  logic          hit;

  assign full  = (row_count_q == CW'(TABLE_DEPTH));
  assign rd_id = rd_data_q[3*SW-1:2*SW];
  assign rd_v1 = rd_data_q[2*SW-1:SW];
  assign rd_v2 = rd_data_q[SW-1:0];

  always_comb begin
    case (key_sel_q)
      KEY_ID:   rd_key = rd_id;
      KEY_VAL1: rd_key = rd_v1;
      default:  rd_key = rd_v2;
    endcase
  end

  assign hit = rd_valid_q && (key_sel_q != KEY_NONE) && (rd_key == probe_key_q);

  // a pending match is sent once the next match or the end of the scan shows up
  assign out_valid_d = pend_valid_q && (hit || cmd_i.flush);

  assign sts_o.empty     = (row_count_q == '0);
  assign sts_o.last_addr = (CW'(scan_q) == row_count_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[row_count_q[AW-1:0]] <= {to_sw(item_i.row_id), to_sw(item_i.row_val1),
                                   to_sw(item_i.row_val2)};
    end
    if (cmd_i.rd) rd_data_q <= mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      case (key_sel_q)
        KEY_ID:   probe_key_q <= to_sw(item_i.row_id);
        KEY_VAL1: probe_key_q <= to_sw(item_i.row_val1);
        default:  probe_key_q <= to_sw(item_i.row_val2);
      endcase
    end
    if (hit) pend_q <= rd_data_q;
    if (out_valid_d) begin
      out_q.match_id   <= from_sw(pend_q[3*SW-1:2*SW]);
      out_q.match_val1 <= from_sw(pend_q[2*SW-1:SW]);
      out_q.match_val2 <= from_sw(pend_q[SW-1:0]);
      out_q.last       <= cmd_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sel_q    <= KEY_ID;
      row_count_q  <= '0;
      scan_q       <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) key_sel_q <= cfg_data_i;
      if (cmd_i.load && !full) row_count_q <= row_count_q + CW'(1);
      if (cmd_i.probe) begin
        scan_q <= '0;
      end else if (cmd_i.rd) begin
        scan_q <= scan_q + AW'(1);
      end
      rd_valid_q  <= cmd_i.rd;
      out_valid_q <= out_valid_d;
      if (cmd_i.probe || cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end else if (hit) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

@@ rtl/nested_loop_equi_join_top.sv @@
// Load: busy stays low, the next transaction may follow at once.
// Probe over N stored rows, N > 0: busy for the scan, drain and flush states, one
// memory read per cycle during the scan; results strobe while busy, and the one marked
// last comes in the cycle after busy falls. A probe of an empty table leaves busy low
// and gives nothing. No new transaction is taken while busy. Results cannot be stalled.
// Async active-low reset empties the table and sets the key to id; row contents
// are not cleared.
module nested_loop_equi_join_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  nlej_pkg::in_t  item_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_data_i,
  output logic           result_valid_o,
  output nlej_pkg::out_t result_o
);
  import nlej_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nlej_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (item_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  nlej_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ rtl/nlej_checker.sv @@
module nlej_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input nlej_pkg::in_t  item_i,
  input logic           result_valid_o,
  input nlej_pkg::out_t result_o
);
  import nlej_pkg::*;

  // a load transaction never occupies the block
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (item_i.op == OP_LOAD) |=> !busy_o)
    else $error("load made the block busy");

  // no results while busy_o and its past value are both low
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !$past(busy_o) |-> !result_valid_o)
    else $error("result while idle");

  // non-final matches go out while the block is busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("non-final result outside a probe");

  // final match comes as the block turns idle, and nothing right after it
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy_o ##1 !result_valid_o)
    else $error("final result misplaced");

endmodule

bind nested_loop_equi_join_top nlej_checker u_nlej_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
